>>> src/vmcb_pkg.sv
// Package: types and constants for the voice mixer with crowd bed.
package vmcb_pkg;

  localparam int MaxVoices   = 24;
  localparam int ClipWords   = 524288;
  localparam int NumSounds   = 16;
  localparam int SwellPeriod = 24000;
  localparam int VoiceIdxW   = $clog2(MaxVoices);
  localparam int ClipAddrW   = $clog2(ClipWords);

  localparam logic signed [31:0] QOne  = 32'sd16777216;
  localparam logic signed [31:0] KP0A  = 32'sd16737790;
  localparam logic signed [31:0] KP0B  = 32'sd1661716;
  localparam logic signed [31:0] KP1A  = 32'sd16156459;
  localparam logic signed [31:0] KP1B  = 32'sd4974720;
  localparam logic signed [31:0] KP2A  = 32'sd9563013;
  localparam logic signed [31:0] KP2B  = 32'sd17661229;
  localparam logic signed [31:0] KPW   = 32'sd3100430;
  localparam logic signed [31:0] KHP   = 32'sd671089;
  localparam logic signed [31:0] KExc  = 32'sd839;
  localparam logic signed [31:0] KSwl  = 32'sd1678;
  localparam logic signed [31:0] KBr0  = 32'sd1677722;
  localparam logic signed [31:0] KBr1  = 32'sd3355443;
  localparam logic signed [31:0] KDv0  = 32'sd7549747;
  localparam logic signed [31:0] KDv1  = 32'sd15938355;
  localparam logic signed [31:0] KBed0 = 32'sd754975;
  localparam logic signed [31:0] KBed1 = 32'sd1258291;
  localparam logic signed [31:0] KSwd  = 32'sd5033165;

  typedef enum logic [1:0] {
    ReqDesc   = 2'd0,
    ReqSample = 2'd1,
    ReqPlay   = 2'd2,
    ReqTick   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CfgMaster = 2'd0,
    CfgCrowd  = 2'd1,
    CfgReady  = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         sound_id;
    logic [18:0]        clip_addr;
    logic [19:0]        clip_length;
    logic [15:0]        clip_gain;
    logic signed [15:0] sample_value;
    logic [15:0]        play_gain;
    logic [15:0]        excitement_target;
    logic signed [15:0] white_noise;
    logic signed [15:0] swell_noise;
  } req_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic [4:0]         voice_count;
  } rsp_t;

endpackage

>>> src/voice_mixer_with_crowd_bed_top.sv
// Top level: polyphonic clip mixer with crowd bed, iterative shared multiplier.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid_i/ready_o  | req_i   (vmcb_pkg::req_t)
//  rsp     | out       | rsp_valid_o/ready_i  | rsp_o   (vmcb_pkg::rsp_t)
//  cfg     | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//
// Loads and ignored plays keep the block idle; a play goes through StPlay and
// StPlay2, after a full pool shifts out the oldest voice one entry a cycle.
// A ready tick does a clip read, multiply and compact per active voice, then
// runs 14 crowd steps, the divider, 6 output steps and the output load.
// Reset clears control and filter state; clip and voice stores are not cleared.
// A result waits in the output register while the next requests are taken; a
// finished tick holds before the output load until that register frees up.
module voice_mixer_with_crowd_bed_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  vmcb_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output vmcb_pkg::rsp_t  rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [16:0]     cfg_data_i
);
  import vmcb_pkg::*;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StShift = 12'b000000000010,
    StPlay  = 12'b000000000100,
    StVRd   = 12'b000000001000,
    StVMul  = 12'b000000010000,
    StVAcc  = 12'b000000100000,
    StCrowd = 12'b000001000000,
    StDiv   = 12'b000010000000,
    StPost  = 12'b000100000000,
    StOut   = 12'b001000000000,
    StWait  = 12'b010000000000,
    StPlay2 = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]           mem_q [ClipWords];
  logic [18:0]           start_q [NumSounds];
  logic [19:0]           len_q [NumSounds];
  logic [15:0]           cgain_q [NumSounds];
  logic [3:0]            vsnd_q [MaxVoices];
  logic [19:0]           vpos_q [MaxVoices];
  logic [31:0]           vgain_q [MaxVoices];

  logic [16:0]           master_q, crowd_q;
  logic                  ready_q;
  req_t                  in_q;
  logic [4:0]            active_q, kept_q;
  logic [VoiceIdxW-1:0]  vi_q;
  logic signed [15:0]    rd_q;
  logic signed [63:0]    acc_q;
  logic signed [31:0]    p0_q, p1_q, p2_q, lp1_q, lp2_q, hp_q, exc_q, swl_q, sgoal_q;
  logic [15:0]           scnt_q;
  logic [4:0]            step_q;
  logic signed [31:0]    t0_q, t1_q, t2_q, mix_q, bright_q;
  logic signed [31:0]    pm_q;
  rsp_t                  out_q;
  logic                  out_v_q;
  logic [5:0]            dcnt_q;
  logic [63:0]           num_q, rem_q;
  logic [31:0]           den_q, quo_q;
  logic                  neg_q;

  // shared multiplier: round half up, floor shift by 24
  logic signed [31:0] ma, mb, mres;
  logic signed [63:0] mprod;
  assign mprod = 64'(ma) * 64'(mb) + 64'sd8388608;
  assign mres  = 32'(mprod >>> 24);

  logic [4:0] vidx5;
  assign vidx5 = 5'(vi_q);
  logic [3:0]  csnd;
  logic [19:0] cpos, clen;
  logic        cplay, ckeep;
  logic [20:0] caddr;
  assign csnd  = vsnd_q[vi_q];
  assign cpos  = vpos_q[vi_q];
  assign clen  = len_q[csnd];
  assign cplay = cpos < clen;
  assign caddr = 21'(start_q[csnd]) + 21'(cpos);
  assign ckeep = (cplay ? cpos + 20'd1 : cpos) < clen;

  logic [15:0] pg;
  assign pg = (in_q.play_gain > 16'd24576) ? 16'd24576 : in_q.play_gain;

  logic out_load;
  assign out_load = (state_q == StOut) && (!out_v_q || rsp_ready_i);

  assign req_ready_o = (state_q == StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !out_v_q && !req_valid_i;
  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

  logic signed [31:0] sw9, wn9, ex8;
  assign sw9 = 32'(in_q.swell_noise) <<< 9;
  assign wn9 = 32'(in_q.white_noise) <<< 9;
  assign ex8 = 32'({in_q.excitement_target, 8'd0});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      5'd0:  begin ma = ex8 - exc_q;    mb = KExc; end
      5'd1:  begin ma = sgoal_q - swl_q; mb = KSwl; end
      5'd2:  begin ma = KBr1;            mb = exc_q; end
      5'd3:  begin ma = KP0A;            mb = p0_q; end
      5'd4:  begin ma = wn9;             mb = KP0B; end
      5'd5:  begin ma = KP1A;            mb = p1_q; end
      5'd6:  begin ma = wn9;             mb = KP1B; end
      5'd7:  begin ma = KP2A;            mb = p2_q; end
      5'd8:  begin ma = wn9;             mb = KP2B; end
      5'd9:  begin ma = wn9;             mb = KPW; end
      5'd10: begin ma = t0_q - lp1_q;    mb = bright_q; end
      5'd11: begin ma = lp1_q - lp2_q;   mb = bright_q; end
      5'd12: begin ma = lp2_q - hp_q;    mb = KHP; end
      5'd13: begin ma = KDv1;            mb = bright_q; end
      5'd14: begin ma = KBed1;           mb = exc_q; end
      5'd15: begin ma = t0_q;            mb = KBed0 + t1_q; end
      5'd16: begin ma = KSwd;            mb = swl_q; end
      5'd17: begin ma = t0_q;            mb = QOne + t1_q; end
      5'd18: begin ma = t0_q;            mb = 32'({crowd_q, 8'd0}); end
      5'd19: begin ma = mix_q + t0_q;    mb = pm_q; end
      default: ;
    endcase
  end

  logic signed [31:0] sclamp;
  logic signed [63:0] pcm64;
  assign sclamp = (mres > QOne) ? QOne : ((mres < -QOne) ? -QOne : mres);
  assign pcm64  = (64'(t0_q) * 64'sd32000 + 64'sd8388608) >>> 24;

  logic [63:0] rem_sh;
  assign rem_sh = {rem_q[62:0], num_q[63]};

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_valid_i && req_ready_o) begin
      if (req_i.req_type == ReqDesc) begin
        start_q[req_i.sound_id] <= req_i.clip_addr;
        len_q[req_i.sound_id]   <= req_i.clip_length;
        cgain_q[req_i.sound_id] <= req_i.clip_gain;
      end
      if (req_i.req_type == ReqSample) mem_q[req_i.clip_addr] <= req_i.sample_value;
    end
    if (state_q == StVRd) rd_q <= (caddr < 21'(ClipWords)) ?
                                  mem_q[caddr[ClipAddrW-1:0]] : 16'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StShift) begin
      vsnd_q[vi_q]  <= vsnd_q[vi_q + 1'b1];
      vpos_q[vi_q]  <= vpos_q[vi_q + 1'b1];
      vgain_q[vi_q] <= vgain_q[vi_q + 1'b1];
    end else if (state_q == StPlay2) begin
      vsnd_q[vi_q]  <= in_q.sound_id;
      vpos_q[vi_q]  <= '0;
      vgain_q[vi_q] <= 32'((32'(cgain_q[in_q.sound_id]) * 32'(pg) + 32'd32) >> 6);
    end else if (state_q == StVAcc && ckeep) begin
      vsnd_q[kept_q[VoiceIdxW-1:0]]  <= csnd;
      vpos_q[kept_q[VoiceIdxW-1:0]]  <= cplay ? cpos + 20'd1 : cpos;
      vgain_q[kept_q[VoiceIdxW-1:0]] <= vgain_q[vi_q];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_valid_i && req_ready_o) begin
        case (req_i.req_type)
          ReqPlay: if (ready_q && req_i.play_gain != 16'd0)
            state_d = (active_q >= 5'(MaxVoices)) ? StShift : StPlay;
          ReqTick: state_d = ready_q ? (active_q == 5'd0 ? StCrowd : StVRd) : StOut;
          default: ;
        endcase
      end
      StShift: if (vidx5 == 5'(MaxVoices - 2)) state_d = StPlay;
      StPlay:  state_d = StPlay2;
      StPlay2: state_d = StIdle;
      StVRd:   state_d = StVMul;
      StVMul:  state_d = StVAcc;
      StVAcc:  state_d = (vidx5 + 5'd1 >= active_q) ? StCrowd : StVRd;
      StCrowd: if (step_q == 5'd13) state_d = StDiv;
      StDiv:   if (dcnt_q == 6'd0) state_d = StPost;
      StPost:  if (step_q == 5'd19) state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      StWait:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      master_q <= 17'd65536;
      crowd_q  <= 17'd65536;
      ready_q  <= 1'b0;
      active_q <= '0;
      kept_q   <= '0;
      vi_q     <= '0;
      p0_q <= '0; p1_q <= '0; p2_q <= '0;
      lp1_q <= '0; lp2_q <= '0; hp_q <= '0;
      exc_q <= '0; swl_q <= '0; sgoal_q <= '0; scnt_q <= '0;
      step_q   <= '0;
      out_v_q  <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_v_q <= 1'b1;
      else if (rsp_valid_o && rsp_ready_i) out_v_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgMaster: master_q <= cfg_data_i;
          CfgCrowd:  crowd_q  <= cfg_data_i;
          CfgReady:  ready_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (req_valid_i && req_ready_o) in_q <= req_i;
          vi_q   <= '0;
          kept_q <= '0;
          acc_q  <= '0;
          step_q <= '0;
        end
        StShift: vi_q <= vi_q + 1'b1;
        StPlay: begin
          if (active_q >= 5'(MaxVoices)) begin
            vi_q <= VoiceIdxW'(MaxVoices - 1);
            active_q <= 5'(MaxVoices);
          end else begin
            vi_q <= active_q[VoiceIdxW-1:0];
            active_q <= active_q + 5'd1;
          end
        end
        StVMul: acc_q <= acc_q + (cplay ? 64'(rd_q) * $signed({1'b0, vgain_q[vi_q]}) : 64'sd0);
        StVAcc: begin
          if (ckeep) kept_q <= kept_q + 5'd1;
          vi_q <= vi_q + 1'b1;
          if (vidx5 + 5'd1 >= active_q) active_q <= kept_q + 5'(ckeep);
        end
        StCrowd: begin
          step_q <= step_q + 5'd1;
          unique case (step_q)
            5'd0: begin
              mix_q <= 32'((acc_q + 64'sd16384) >>> 15);
              exc_q <= exc_q + mres;
              if (scnt_q <= 16'd1) begin
                scnt_q <= 16'(SwellPeriod);
                sgoal_q <= sw9;
              end else scnt_q <= scnt_q - 16'd1;
            end
            5'd1:  swl_q <= swl_q + mres;
            5'd2:  bright_q <= KBr0 + mres;
            5'd3:  t0_q <= mres;
            5'd4:  p0_q <= t0_q + mres;
            5'd5:  t0_q <= mres;
            5'd6:  p1_q <= t0_q + mres;
            5'd7:  t0_q <= mres;
            5'd8:  p2_q <= t0_q + mres;
            5'd9:  t0_q <= p0_q + p1_q + p2_q + mres;
            5'd10: lp1_q <= lp1_q + mres;
            5'd11: lp2_q <= lp2_q + mres;
            5'd12: hp_q <= hp_q + mres;
            5'd13: begin
              den_q  <= 32'(KDv0 + mres);
              neg_q  <= (lp2_q - hp_q) < 0;
              num_q  <= 64'(((lp2_q - hp_q) < 0) ? -(33'(lp2_q) - 33'(hp_q))
                                                 : (33'(lp2_q) - 33'(hp_q))) << 31;
              rem_q  <= '0;
              quo_q  <= '0;
              dcnt_q <= 6'd57;
            end
            default: ;
          endcase
        end
        StDiv: begin
          num_q <= num_q << 1;
          if (rem_sh >= 64'(den_q)) begin
            rem_q <= rem_sh - 64'(den_q);
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd0) begin
            t0_q <= neg_q ? -quo_q : quo_q;
            pm_q <= (master_q > 17'd65536) ? QOne : 32'({master_q, 8'd0});
          end
        end
        StPost: begin
          step_q <= step_q + 5'd1;
          unique case (step_q)
            5'd14: t1_q <= mres;
            5'd15: t0_q <= mres;
            5'd16: t1_q <= mres;
            5'd17: t0_q <= mres;
            5'd18: t0_q <= mres;
            5'd19: t0_q <= sclamp;
            default: ;
          endcase
        end
        StOut: if (out_load) begin
          out_q.pcm_sample  <= ready_q ? 16'(pcm64) : 16'sd0;
          out_q.voice_count <= active_q;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/vmcb_checker.sv
// Checker: port-level properties of the voice mixer, bound to the top level.
module vmcb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input vmcb_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input vmcb_pkg::rsp_t rsp_o,
  input logic           cfg_valid_i,
  input logic           cfg_ready_o
);
  import vmcb_pkg::*;

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.voice_count <= 5'(MaxVoices)) else $error("count");
  a_pcm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.pcm_sample <= 16'sd32000 && rsp_o.pcm_sample >= -16'sd32000))
    else $error("pcm range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o && req_i.req_type == ReqTick |=> !req_ready_o)
    else $error("not busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o)) else $error("hold");
endmodule

bind voice_mixer_with_crowd_bed_top vmcb_checker u_vmcb_checker (.*);

>>> test/tb_top.sv
// Testbench for the voice mixer with crowd bed: randomized requests checked against a mixer model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vmcb_pkg::*;

  class mixer_model;
    logic [15:0] clip_mem [int];
    int unsigned clip_start [NumSounds];
    int unsigned clip_len [NumSounds];
    int unsigned clip_gain [NumSounds];
    int unsigned v_sound [MaxVoices];
    int unsigned v_pos [MaxVoices];
    int unsigned v_gain [MaxVoices];
    int unsigned n_active;
    int pole [3];
    int lp_a, lp_b, hp_trk, exc_lvl, swl_lvl, swl_goal;
    int unsigned swl_cnt;
    int unsigned master_vol, crowd_lvl;
    bit mix_on;
    rsp_t pcm_due [$];
    int errors;

    function new();
      n_active = 0;
      pole = '{0, 0, 0};
      lp_a = 0; lp_b = 0; hp_trk = 0; exc_lvl = 0; swl_lvl = 0; swl_goal = 0;
      swl_cnt = 0;
      master_vol = 65536; crowd_lvl = 65536; mix_on = 0;
      errors = 0;
    endfunction

    function int mulq(longint a, longint b);
      longint p;
      p = a * b + 64'sd8388608;
      return int'(p >>> 24);
    endfunction

    function void write_reg(cfg_e idx, logic [16:0] val);
      case (idx)
        CfgMaster: master_vol = 32'(val);
        CfgCrowd:  crowd_lvl = 32'(val);
        CfgReady:  mix_on = val[0];
        default: ;
      endcase
    endfunction

    function void start_voice(int unsigned snd, int unsigned pg);
      if (pg > 24576) pg = 24576;
      if (n_active >= MaxVoices) begin
        for (int i = 1; i < MaxVoices; i++) begin
          v_sound[i-1] = v_sound[i];
          v_pos[i-1] = v_pos[i];
          v_gain[i-1] = v_gain[i];
        end
        n_active = MaxVoices - 1;
      end
      v_sound[n_active] = snd;
      v_pos[n_active] = 0;
      v_gain[n_active] = (clip_gain[snd] * pg + 32) >> 6;
      n_active++;
    endfunction

    function int crowd_step(int w, int bright);
      int pink, d;
      pole[0] = mulq(KP0A, pole[0]) + mulq(w, KP0B);
      pole[1] = mulq(KP1A, pole[1]) + mulq(w, KP1B);
      pole[2] = mulq(KP2A, pole[2]) + mulq(w, KP2B);
      pink = pole[0] + pole[1] + pole[2] + mulq(w, KPW);
      lp_a += mulq(longint'(pink) - longint'(lp_a), bright);
      lp_b += mulq(longint'(lp_a) - longint'(lp_b), bright);
      hp_trk += mulq(longint'(lp_b) - longint'(hp_trk), KHP);
      d = KDv0 + mulq(KDv1, bright);
      if (d <= 0) return 0;
      return int'(((longint'(lp_b) - longint'(hp_trk)) * longint'(QOne)) / longint'(d));
    endfunction

    function int mix_tick(req_t r);
      longint acc;
      int mix, bright, bed, s, smp;
      int unsigned kept, snd, len, addr, mv;
      acc = 0;
      kept = 0;
      for (int i = 0; i < n_active; i++) begin
        snd = v_sound[i];
        len = clip_len[snd];
        if (v_pos[i] < len) begin
          addr = clip_start[snd] + v_pos[i];
          smp = 0;
          if (addr < ClipWords && clip_mem.exists(addr)) smp = int'($signed(clip_mem[addr]));
          acc += longint'(smp) * longint'(v_gain[i]);
          v_pos[i]++;
        end
        if (v_pos[i] < len) begin
          v_sound[kept] = v_sound[i];
          v_pos[kept] = v_pos[i];
          v_gain[kept] = v_gain[i];
          kept++;
        end
      end
      n_active = kept;
      mix = int'((acc + 64'sd16384) >>> 15);
      exc_lvl += mulq(longint'(r.excitement_target) * 256 - longint'(exc_lvl), KExc);
      if (swl_cnt <= 1) begin
        swl_cnt = SwellPeriod;
        swl_goal = int'(r.swell_noise) * 512;
      end else begin
        swl_cnt--;
      end
      swl_lvl += mulq(longint'(swl_goal) - longint'(swl_lvl), KSwl);
      bright = KBr0 + mulq(KBr1, exc_lvl);
      bed = crowd_step(int'(r.white_noise) * 512, bright);
      bed = mulq(bed, KBed0 + mulq(KBed1, exc_lvl));
      bed = mulq(bed, QOne + mulq(KSwd, swl_lvl));
      bed = mulq(bed, longint'(crowd_lvl) * 256);
      mix += bed;
      mv = (master_vol > 65536) ? 65536 : master_vol;
      s = mulq(mix, longint'(mv) * 256);
      if (s > QOne) s = QOne;
      if (s < -QOne) s = -QOne;
      return int'((longint'(s) * 32000 + 64'sd8388608) >>> 24);
    endfunction

    function void note_request(req_t r);
      rsp_t o;
      int pcm;
      case (req_e'(r.req_type))
        ReqDesc: begin
          clip_start[r.sound_id] = 32'(r.clip_addr);
          clip_len[r.sound_id] = 32'(r.clip_length);
          clip_gain[r.sound_id] = 32'(r.clip_gain);
        end
        ReqSample: clip_mem[r.clip_addr] = r.sample_value;
        ReqPlay: if (mix_on && r.play_gain != 0)
          start_voice(32'(r.sound_id), 32'(r.play_gain));
        default: begin
          pcm = mix_on ? mix_tick(r) : 0;
          o.pcm_sample = pcm[15:0];
          o.voice_count = n_active[4:0];
          pcm_due.push_back(o);
        end
      endcase
    endfunction

    function void check_sample(rsp_t got);
      rsp_t want;
      if (pcm_due.size() == 0) begin
        $error("unexpected result pcm_sample=%0d voice_count=%0d",
               got.pcm_sample, got.voice_count);
        errors++;
        return;
      end
      want = pcm_due.pop_front();
      if (got.pcm_sample !== want.pcm_sample) begin
        $error("pcm_sample expected %0d actual %0d", want.pcm_sample, got.pcm_sample);
        errors++;
      end
      if (got.voice_count !== want.voice_count) begin
        $error("voice_count expected %0d actual %0d", want.voice_count, got.voice_count);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_valid, cfg_ready;
  req_t req_data;
  rsp_t rsp_data;
  logic [1:0] cfg_idx;
  logic [16:0] cfg_data;

  mixer_model model;
  bit quick_tx, quick_rx, hold_rsp;

  voice_mixer_with_crowd_bed_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req_data),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(req_t r);
    int gap;
    gap = quick_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    model.note_request(r);
  endtask

  // hold until every tick result is back and loads have settled
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (model.pcm_due.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_e idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t noise_req(req_e kind);
    req_t r;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  // descriptor whose in-range addresses all lie in the preloaded windows
  function automatic req_t make_desc(int snd);
    req_t r;
    r = noise_req(ReqDesc);
    r.sound_id = 4'(snd);
    if ($urandom_range(0, 1)) begin
      r.clip_addr = 19'($urandom_range(0, 255));
      r.clip_length = 20'($urandom_range(0, 256 - int'(r.clip_addr)));
    end else begin
      r.clip_addr = 19'($urandom_range(524256, 524287));
      r.clip_length = 20'($urandom_range(0, 524288));
    end
    return r;
  endfunction

  function automatic req_t make_sample(int unsigned addr);
    req_t r;
    r = noise_req(ReqSample);
    r.clip_addr = addr[18:0];
    return r;
  endfunction

  function automatic req_t make_play();
    req_t r;
    r = noise_req(ReqPlay);
    case ($urandom_range(0, 5))
      0: r.play_gain = 16'hffff;
      1: r.play_gain = 16'd0;
      2: r.play_gain = 16'($urandom_range(1, 24576));
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_phase(int count, int play_pct, int pressure);
    int pick;
    req_t r;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) quick_tx = ($urandom_range(0, 3) == 0);
      if (pressure == 1 && n == count / 2) hold_rsp = 1;
      if (pressure == 2 && n == count / 2) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (model.pcm_due.size() > 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < play_pct) r = make_play();
      else if (pick < play_pct + 8) r = make_desc($urandom_range(0, NumSounds - 1));
      else if (pick < play_pct + 20)
        r = $urandom_range(0, 3) == 0 ? make_sample($urandom)
          : make_sample($urandom_range(0, 1) ? $urandom_range(0, 255)
                                             : $urandom_range(524256, 524287));
      else r = noise_req(ReqTick);
      send(r);
    end
  endtask

  initial begin
    int w;
    forever begin
      if (hold_rsp) begin
        w = 400;
        hold_rsp = 0;
      end else begin
        if ($urandom_range(0, 40) == 0) quick_rx = ~quick_rx;
        w = quick_rx ? 0 : $urandom_range(0, 10);
      end
      if (w > 0) begin
        rsp_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      model.check_sample(rsp_data);
    end
  end

  initial begin
    req_t r;
    model = new();
    rst_n = 1'b0;
    req_valid = 1'b0;
    req_data = '0;
    rsp_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_idx = CfgMaster;
    cfg_data = '0;
    quick_tx = 0;
    quick_rx = 0;
    hold_rsp = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill clip windows and all descriptors while the mixer is off
    quick_tx = 1;
    for (int a = 0; a < 256; a++) send(make_sample(a));
    for (int a = 524256; a < 524288; a++) send(make_sample(a));
    for (int s = 0; s < NumSounds; s++) send(make_desc(s));
    r = make_sample(3); r.sample_value = 16'sh7fff; send(r);
    r = make_sample(4); r.sample_value = -16'sh8000; send(r);
    r = make_sample(0); r.sample_value = 16'sh0000; send(r);
    r = make_sample(524287); r.sample_value = -16'sh8000; send(r);
    quick_tx = 0;
    send(make_play());
    send(noise_req(ReqTick));
    send(noise_req(ReqTick));
    drain();

    write_cfg(CfgMaster, 17'd65536);
    write_cfg(CfgCrowd, 17'd65536);
    write_cfg(CfgReady, 17'd1);

    r = make_desc(0); r.clip_addr = 3; r.clip_length = 2; r.clip_gain = 16'hffff; send(r);
    r = make_desc(1); r.clip_length = 0; send(r);
    r = make_desc(2); r.clip_addr = 19'h7ffff; r.clip_length = 20'd524288;
    r.clip_gain = 0; send(r);
    r = make_desc(15); r.clip_addr = 0; r.clip_length = 256; send(r);
    r = make_play(); r.sound_id = 0; r.play_gain = 16'hffff; send(r);
    r = make_play(); r.sound_id = 1; r.play_gain = 16'd100; send(r);
    r = make_play(); r.sound_id = 2; r.play_gain = 0; send(r);
    r = make_play(); r.sound_id = 2; r.play_gain = 16'd16384; send(r);
    r = make_play(); r.sound_id = 15; r.play_gain = 16'd24577; send(r);
    r = noise_req(ReqTick); r.excitement_target = 16'hffff;
    r.white_noise = 16'sh7fff; r.swell_noise = 16'sh7fff; send(r);
    r = noise_req(ReqTick); r.excitement_target = 0;
    r.white_noise = -16'sh8000; r.swell_noise = -16'sh8000; send(r);
    r = make_desc(0); r.clip_addr = 3; r.clip_length = 0; send(r);
    for (int k = 0; k < 3; k++) send(noise_req(ReqTick));
    for (int k = 0; k < 26; k++) send(make_play());
    send(noise_req(ReqTick));
    drain();

    write_cfg(CfgMaster, 17'h1ffff);
    write_cfg(CfgCrowd, 17'd0);
    random_phase(260, 25, 1);
    drain();

    write_cfg(CfgMaster, 17'd0);
    write_cfg(CfgCrowd, 17'h1ffff);
    random_phase(220, 20, 2);
    drain();

    write_cfg(CfgMaster, 17'($urandom_range(0, 131071)));
    write_cfg(CfgCrowd, 17'($urandom_range(0, 131071)));
    random_phase(300, 45, 0);
    drain();

    write_cfg(CfgReady, 17'd0);
    random_phase(60, 25, 0);
    drain();

    write_cfg(CfgReady, 17'd1);
    write_cfg(CfgMaster, 17'd65536);
    write_cfg(CfgCrowd, 17'($urandom_range(0, 65536)));
    random_phase(300, 30, 1);
    drain();

    if (model.errors == 0 && model.pcm_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> sim.f
src/vmcb_pkg.sv
src/voice_mixer_with_crowd_bed_top.sv
src/vmcb_checker.sv
test/tb_top.sv
